>>> hdl/auto_backlight_level_control_defines.svh
// assertion macros for the backlight level control
`ifndef AUTO_BACKLIGHT_LEVEL_CONTROL_DEFINES_SVH
`define AUTO_BACKLIGHT_LEVEL_CONTROL_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define ABL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ABL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/abl_pkg.sv
package abl_pkg;

	localparam int SMP_W      = 12;
	localparam int PCT_W      = 7;
	localparam int LVL_W      = 4;
	localparam int CNT_W      = 5;
	localparam int CMD_W      = 2;
	localparam int IVL_W      = 8;
	localparam int MARGIN_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MANUAL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HYST_MARGIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_INTERVAL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_INTERVAL = 3'd4;

	localparam logic                RST_AUTO_ENABLE     = 1'b0;
	localparam logic [MARGIN_W-1:0] RST_HYST_MARGIN     = 8'd40;
	localparam logic [CNT_W-1:0]    RST_DEBOUNCE_LIMIT  = 5'd10;
	localparam logic [IVL_W-1:0]    RST_INIT_INTERVAL   = 8'd1;
	localparam logic [IVL_W-1:0]    RST_NORMAL_INTERVAL = 8'd50;

	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	localparam logic [SMP_W-1:0] THRESH_TAB [16] = '{
		12'd409, 12'd819, 12'd1228, 12'd1638, 12'd2048, 12'd2457, 12'd2867, 12'd3276,
		12'd3686, 12'd4030, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095
	};

	localparam logic [PCT_W-1:0] PCT_TAB [16] = '{
		7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80,
		7'd90, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
	};

	typedef struct packed {
		logic             fill_end;
		logic             regulate;
		logic             manual;
		logic             init_after;
		logic [LVL_W-1:0] man_level;
	} abl_ctl_t;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? CNT_MAX : c + CNT_W'(1);
	endfunction

endpackage

>>> hdl/abl_window.sv
module abl_window #(
	parameter int WINDOW = 10,
	parameter int LEVELS = 10,
	localparam int SUM_W = abl_pkg::SMP_W + $clog2(WINDOW)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         auto_enable,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [abl_pkg::CMD_W-1:0]    command,
	input  logic [abl_pkg::SMP_W-1:0]    light_sample,
	input  logic [abl_pkg::PCT_W-1:0]    manual_brightness,
	output logic                         s2_valid,
	input  logic                         s2_ready,
	output abl_pkg::abl_ctl_t            s2_ctl,
	output logic [SUM_W-1:0]             s2_sum
);
	import abl_pkg::*;

	localparam int IDX_W = $clog2(WINDOW);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	logic [SMP_W-1:0] window_mem [WINDOW];

	logic [IDX_W-1:0] wr_idx_q;
	logic             init_q;
	logic [SUM_W-1:0] sum_q;
	logic             in_acc;
	logic             is_sample;
	logic             do_restart;
	logic             init_next;
	logic [LVL_W-1:0] man_level;
	logic             s1_free;
	logic             s2_free;

	logic             v1_s1;
	logic             first_s1;
	logic             fill_s1;
	logic [SMP_W-1:0] sample_s1;
	logic [SMP_W-1:0] old_s1;
	abl_ctl_t         ctl_s1;
	logic [SUM_W-1:0] sum_next;

	logic             v2_s2;
	abl_ctl_t         ctl_s2;
	logic [SUM_W-1:0] sum_s2;

	assign s2_free  = !v2_s2 || s2_ready;
	assign s1_free  = !v1_s1 || s2_free;
	assign in_ready = s1_free;
	assign in_acc   = in_valid && in_ready;

	assign is_sample  = (command == CMD_SAMPLE) && auto_enable;
	assign do_restart = (command == CMD_RESTART) && auto_enable && !init_q;

	always_comb begin
		init_next = init_q;
		if (is_sample && init_q && (wr_idx_q == IDX_LAST)) begin
			init_next = 1'b0;
		end else if (do_restart) begin
			init_next = 1'b1;
		end
	end

	// first level whose percent covers the request
	always_comb begin
		man_level = LVL_W'(LEVELS - 1);
		for (int i = LEVELS - 2; i >= 0; i--) begin
			if (manual_brightness <= PCT_TAB[i]) begin
				man_level = LVL_W'(i);
			end
		end
	end

	// write index and fill phase move at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			init_q   <= 1'b1;
		end else if (in_acc) begin
			init_q <= init_next;
			if (is_sample) begin
				wr_idx_q <= (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + IDX_W'(1);
			end else if (do_restart) begin
				wr_idx_q <= '0;
			end
		end
	end

	// read of the outgoing entry and write of the new one share the address
	always_ff @(posedge clk) begin
		if (in_acc && is_sample) begin
			old_s1                 <= window_mem[wr_idx_q];
			window_mem[wr_idx_q]   <= light_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (s1_free) begin
			v1_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1            <= light_sample;
			first_s1             <= is_sample && init_q && (wr_idx_q == '0);
			fill_s1              <= is_sample && init_q;
			ctl_s1.fill_end      <= is_sample && init_q && (wr_idx_q == IDX_LAST);
			ctl_s1.regulate      <= is_sample && !init_q;
			ctl_s1.manual        <= (command == CMD_MANUAL);
			ctl_s1.init_after    <= init_next;
			ctl_s1.man_level     <= man_level;
		end
	end

	// running window sum
	always_comb begin
		sum_next = sum_q;
		if (first_s1) begin
			sum_next = SUM_W'(sample_s1);
		end else if (fill_s1) begin
			sum_next = sum_q + SUM_W'(sample_s1);
		end else if (ctl_s1.regulate) begin
			sum_next = sum_q - SUM_W'(old_s1) + SUM_W'(sample_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v2_s2 <= 1'b0;
		end else begin
			if (v1_s1 && s2_free) begin
				sum_q <= sum_next;
			end
			if (s2_free) begin
				v2_s2 <= v1_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			ctl_s2 <= ctl_s1;
			sum_s2 <= sum_next;
		end
	end

	assign s2_valid = v2_s2;
	assign s2_ctl   = ctl_s2;
	assign s2_sum   = sum_s2;

endmodule

>>> hdl/abl_level.sv
`include "auto_backlight_level_control_defines.svh"

module abl_level #(
	parameter int WINDOW = 10,
	parameter int LEVELS = 10,
	localparam int SUM_W = abl_pkg::SMP_W + $clog2(WINDOW)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [abl_pkg::MARGIN_W-1:0]  hysteresis_margin,
	input  logic [abl_pkg::CNT_W-1:0]     debounce_limit,
	input  logic [abl_pkg::IVL_W-1:0]     init_interval,
	input  logic [abl_pkg::IVL_W-1:0]     normal_interval,
	input  logic                          s2_valid,
	output logic                          s2_ready,
	input  abl_pkg::abl_ctl_t             s2_ctl,
	input  logic [SUM_W-1:0]              s2_sum,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [abl_pkg::PCT_W-1:0]     brightness_percent,
	output logic                          brightness_update,
	output logic [abl_pkg::LVL_W-1:0]     light_level,
	output logic                          initializing,
	output logic [abl_pkg::IVL_W-1:0]     next_interval
);
	import abl_pkg::*;

	localparam int CMP_W = SUM_W + 1;
	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

	logic [LVL_W-1:0] adopted_q;
	logic [LVL_W-1:0] bright_q;
	logic [CNT_W-1:0] up_q;
	logic [CNT_W-1:0] dn_q;
	logic             out_v_q;

	logic [CMP_W-1:0] sum_x;
	logic [CMP_W-1:0] margin_w;
	logic [15:0]      below;
	logic [15:0]      hold_dn;
	logic [15:0]      hold_up;
	logic [LVL_W-1:0] raw_level;
	logic [LVL_W-1:0] new_level;
	logic [LVL_W-1:0] step;
	logic [LVL_W:0]   bright_up;
	logic [CNT_W-1:0] up_pre;
	logic [CNT_W-1:0] dn_pre;

	logic [LVL_W-1:0] adopted_d;
	logic [LVL_W-1:0] bright_d;
	logic [CNT_W-1:0] up_d;
	logic [CNT_W-1:0] dn_d;
	logic             upd_d;
	logic             s2_move;

	assign s2_ready = !out_v_q || out_ready;
	assign s2_move  = s2_valid && s2_ready;

	assign sum_x    = CMP_W'(s2_sum);
	assign margin_w = CMP_W'(hysteresis_margin) * CMP_W'(WINDOW);

	// threshold compares kept in sum units, so no average is formed
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			below[i]   = sum_x < CMP_W'(THRESH_TAB[i]) * CMP_W'(WINDOW);
			hold_dn[i] = (sum_x + margin_w) >= (CMP_W'(THRESH_TAB[i]) + CMP_W'(1)) * CMP_W'(WINDOW);
			hold_up[i] = sum_x < CMP_W'(THRESH_TAB[i]) * CMP_W'(WINDOW) + margin_w;
		end
	end

	always_comb begin
		raw_level = LVL_MAX;
		for (int i = LEVELS - 2; i >= 0; i--) begin
			if (below[i]) begin
				raw_level = LVL_W'(i);
			end
		end
	end

	// hysteresis around the adopted level
	always_comb begin
		new_level = raw_level;
		if (({1'b0, raw_level} + (LVL_W+1)'(1) == {1'b0, adopted_q}) && hold_dn[raw_level]) begin
			new_level = adopted_q;
		end else if (({1'b0, raw_level} == {1'b0, adopted_q} + (LVL_W+1)'(1)) && hold_up[adopted_q]) begin
			new_level = adopted_q;
		end
	end

	always_comb begin
		adopted_d = adopted_q;
		bright_d  = bright_q;
		up_d      = up_q;
		dn_d      = dn_q;
		upd_d     = 1'b0;
		step      = '0;
		bright_up = '0;
		up_pre    = up_q;
		dn_pre    = dn_q;
		if (s2_ctl.fill_end) begin
			adopted_d = raw_level;
			bright_d  = raw_level;
			upd_d     = 1'b1;
		end else if (s2_ctl.regulate) begin
			if (new_level > adopted_q) begin
				step   = new_level - adopted_q;
				up_pre = (step > LVL_W'(1)) ? bump(up_q) : up_q;
				if (up_pre < debounce_limit) begin
					up_d = bump(up_pre);
				end else begin
					up_d      = up_pre;
					bright_up = {1'b0, bright_q} + {1'b0, step};
					bright_d  = (bright_up > {1'b0, LVL_MAX}) ? LVL_MAX : bright_up[LVL_W-1:0];
					adopted_d = new_level;
					upd_d     = 1'b1;
				end
			end else if (new_level < adopted_q) begin
				step   = adopted_q - new_level;
				dn_pre = (step > LVL_W'(1)) ? bump(dn_q) : dn_q;
				if (dn_pre < debounce_limit) begin
					dn_d = bump(dn_pre);
				end else begin
					dn_d      = dn_pre;
					bright_d  = (bright_q >= step) ? bright_q - step : '0;
					adopted_d = new_level;
					upd_d     = 1'b1;
				end
			end else begin
				up_d = '0;
				dn_d = '0;
			end
		end else if (s2_ctl.manual) begin
			bright_d = s2_ctl.man_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adopted_q <= LVL_MAX;
			bright_q  <= LVL_MAX;
			up_q      <= '0;
			dn_q      <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (s2_ready) begin
				out_v_q <= s2_valid;
			end
			if (s2_move) begin
				adopted_q <= adopted_d;
				bright_q  <= bright_d;
				up_q      <= up_d;
				dn_q      <= dn_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			brightness_percent <= PCT_TAB[bright_d];
			brightness_update  <= upd_d;
			light_level        <= adopted_d;
			initializing       <= s2_ctl.init_after;
			next_interval      <= s2_ctl.init_after ? init_interval : normal_interval;
		end
	end

	assign out_valid = out_v_q;

	`ABL_ASSERT_NOW(a_level_range, 1'b1, (adopted_q <= LVL_MAX) && (bright_q <= LVL_MAX), "level beyond top level")
	`ABL_ASSERT_NEXT(a_idle_word_holds, s2_move && !s2_ctl.fill_end && !s2_ctl.regulate && !s2_ctl.manual, $stable(adopted_q) && $stable(bright_q), "level moved on an idle word")
	`ABL_ASSERT_NEXT(a_update_source, s2_move && !s2_ctl.fill_end && !s2_ctl.regulate, !brightness_update, "update flagged on a non-sample word")

endmodule

>>> hdl/auto_backlight_level_control.sv
// Automatic backlight level control. Takes one word per clock on the input
// channel when the output side keeps up; each word gives exactly one result,
// presented on the output after the window memory read at acceptance, the
// running-sum update and the level decision into the output register. The
// rate is set by the single-port window memory, read and written once per
// sample at the same address; the sum is kept running, so no sample needs a
// pass over the whole window. No clearing pass follows reset: stored entries
// are only used once a complete fill has written the window. Configuration
// registers (index: auto_enable, hysteresis_margin, debounce_limit,
// init_interval, normal_interval) are to be written by the user only while
// the block is idle; the block itself does not enforce this.
module auto_backlight_level_control #(
	parameter int WINDOW = 10,
	parameter int LEVELS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [abl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [abl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [abl_pkg::CMD_W-1:0]       command,
	input  logic [abl_pkg::SMP_W-1:0]       light_sample,
	input  logic [abl_pkg::PCT_W-1:0]       manual_brightness,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [abl_pkg::PCT_W-1:0]       brightness_percent,
	output logic                            brightness_update,
	output logic [abl_pkg::LVL_W-1:0]       light_level,
	output logic                            initializing,
	output logic [abl_pkg::IVL_W-1:0]       next_interval
);
	import abl_pkg::*;

	localparam int SUM_W = SMP_W + $clog2(WINDOW);

	logic                auto_enable_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [CNT_W-1:0]    limit_q;
	logic [IVL_W-1:0]    init_ivl_q;
	logic [IVL_W-1:0]    norm_ivl_q;

	logic                s2_valid;
	logic                s2_ready;
	abl_ctl_t            s2_ctl;
	logic [SUM_W-1:0]    s2_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_enable_q <= RST_AUTO_ENABLE;
			margin_q      <= RST_HYST_MARGIN;
			limit_q       <= RST_DEBOUNCE_LIMIT;
			init_ivl_q    <= RST_INIT_INTERVAL;
			norm_ivl_q    <= RST_NORMAL_INTERVAL;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_AUTO_ENABLE:     auto_enable_q <= cfg_data[0];
				REG_HYST_MARGIN:     margin_q      <= cfg_data[MARGIN_W-1:0];
				REG_DEBOUNCE_LIMIT:  limit_q       <= cfg_data[CNT_W-1:0];
				REG_INIT_INTERVAL:   init_ivl_q    <= cfg_data[IVL_W-1:0];
				REG_NORMAL_INTERVAL: norm_ivl_q    <= cfg_data[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	abl_window #(
		.WINDOW (WINDOW),
		.LEVELS (LEVELS)
	) u_window (
		.clk               (clk),
		.arst_n            (arst_n),
		.auto_enable       (auto_enable_q),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.light_sample      (light_sample),
		.manual_brightness (manual_brightness),
		.s2_valid          (s2_valid),
		.s2_ready          (s2_ready),
		.s2_ctl            (s2_ctl),
		.s2_sum            (s2_sum)
	);

	abl_level #(
		.WINDOW (WINDOW),
		.LEVELS (LEVELS)
	) u_level (
		.clk                (clk),
		.arst_n             (arst_n),
		.hysteresis_margin  (margin_q),
		.debounce_limit     (limit_q),
		.init_interval      (init_ivl_q),
		.normal_interval    (norm_ivl_q),
		.s2_valid           (s2_valid),
		.s2_ready           (s2_ready),
		.s2_ctl             (s2_ctl),
		.s2_sum             (s2_sum),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.brightness_percent (brightness_percent),
		.brightness_update  (brightness_update),
		.light_level        (light_level),
		.initializing       (initializing),
		.next_interval      (next_interval)
	);

endmodule
